// ----- hw/rtl/cnm_pkg.sv -----
// cnm_pkg: shared types and constants for the cosine nearest-match core.
// Used by all modules under hw/rtl; no dependencies.
`default_nettype none
package cnm_pkg;
	localparam int EMBED_LEN    = 512;
	localparam int MAX_ENTRIES  = 64;
	localparam int ELEM_W       = 16;
	localparam int EIDX_W       = 9;
	localparam int ENT_W        = 6;
	localparam int CNT_W        = 7;
	localparam int MEM_AW       = ENT_W + EIDX_W;
	localparam int PROD_W       = 2 * ELEM_W;
	localparam int ACC_W        = PROD_W + EIDX_W + 1;
	localparam int ROOT_W       = ACC_W / 2;
	localparam int DEN_W        = 2 * ROOT_W;
	localparam int NUM_W        = ACC_W + 15;

	localparam logic [0:0] REG_THRESHOLD = 1'b0;
	localparam logic [0:0] REG_COUNT     = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [ENT_W-1:0]  entry_index;
		logic [EIDX_W-1:0] element_index;
		logic signed [ELEM_W-1:0] element_value;
		logic              query_last;
	} in_item_t;

	typedef struct packed {
		logic              matched;
		logic [ENT_W-1:0]  best_entry;
		logic signed [15:0] best_score;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_acc;     // clear dot/norm accumulators
		logic rd_en;       // read memories at addresses below
		logic acc_en;      // accumulate product of last read
		logic root_start;  // start square roots
		logic div_start;   // start divider
		logic compare;     // fold similarity into best
		logic clr_best;
		logic [ENT_W-1:0]  ent;
		logic [EIDX_W-1:0] elem;
	} cnm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic root_done;
		logic div_done;
	} cnm_sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/cnm_isqrt.sv -----
// cnm_isqrt: bit-pair iterative floor square root, two bits per cycle.
// Depends on cnm_pkg.
`default_nettype none
module cnm_isqrt
	import cnm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [ACC_W-1:0]  value,
	output logic                   done,
	output logic [ROOT_W-1:0]      root
);
	localparam int STEPS = ACC_W / 2;
	localparam int CW = $clog2(STEPS + 1);

	logic [ACC_W-1:0]  rem_q;
	logic [ACC_W-1:0]  val_q;
	logic [ROOT_W-1:0] root_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [ROOT_W+1:0] trial;
	logic [ROOT_W+1:0] rem_next;

	// remainder grows by the next bit pair; trial = 4*root + 1
	assign rem_next = {rem_q[ROOT_W-1:0], val_q[ACC_W-1 -: 2]};
	assign trial    = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[ACC_W-3:0], 2'b00};
			if (rem_next >= trial) begin
				rem_q  <= ACC_W'(rem_next - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= ACC_W'(rem_next);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule
`default_nettype wire

// ----- hw/rtl/cnm_datapath.sv -----
// cnm_datapath: embedding memories, shared MAC, square roots, divider, best tracking.
// Depends on cnm_pkg and cnm_isqrt.
`default_nettype none
module cnm_datapath
	import cnm_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     wr_entry,
	input  wire logic                     wr_query,
	input  wire in_item_t                 item,
	input  wire cnm_cmd_t                 cmd,
	output cnm_sts_t                      sts,
	output logic [ENT_W-1:0]              best_entry,
	output logic signed [15:0]            best_sim,
	output logic                          found
);
	logic signed [ELEM_W-1:0] entry_mem [2**MEM_AW];
	logic signed [ELEM_W-1:0] query_mem [2**EIDX_W];
	logic signed [ELEM_W-1:0] e_s1, q_s1;
	logic signed [PROD_W-1:0] pd_s2, pq_s2, pe_s2;
	logic                     v_s1, v_s2;
	logic signed [ACC_W-1:0]  dot_q, nq_q, ne_q;
	logic [ROOT_W-1:0]        rq, re;
	logic                     dq, de, rdone_q;
	logic [DEN_W-1:0]         den_q;
	logic [NUM_W-1:0]         num_q, quo_q;
	logic [DEN_W:0]           rem_q;
	logic                     neg_q, zero_q, dbusy_q, ddone_q;
	logic [$clog2(NUM_W+1)-1:0] dcnt_q;
	logic [DEN_W:0]           rshift;
	logic signed [16:0]       sim;

	always_ff @(posedge clk) begin
		if (wr_entry)
			entry_mem[{item.entry_index, item.element_index}] <= item.element_value;
		if (wr_query)
			query_mem[item.element_index] <= item.element_value;
		if (cmd.rd_en) begin
			e_s1 <= entry_mem[{cmd.ent, cmd.elem}];
			q_s1 <= query_mem[cmd.elem];
		end
		pd_s2 <= q_s1 * e_s1;
		pq_s2 <= q_s1 * q_s1;
		pe_s2 <= e_s1 * e_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_acc) begin
			dot_q <= '0;
			nq_q  <= '0;
			ne_q  <= '0;
		end else if (v_s2 && cmd.acc_en) begin
			dot_q <= dot_q + ACC_W'(pd_s2);
			nq_q  <= nq_q + ACC_W'(pq_s2);
			ne_q  <= ne_q + ACC_W'(pe_s2);
		end
	end

	cnm_isqrt u_sq_q (.clk, .arst_n, .start(cmd.root_start),
		.value(nq_q), .done(dq), .root(rq));
	cnm_isqrt u_sq_e (.clk, .arst_n, .start(cmd.root_start),
		.value(ne_q), .done(de), .root(re));

	// both roots finish together; register their product
	always_ff @(posedge clk) begin
		if (dq && de)
			den_q <= rq * re;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rdone_q <= 1'b0;
		else
			rdone_q <= dq && de;
	end

	// restoring divider on |dot|*32768 / den, one quotient bit per cycle
	assign rshift = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			ddone_q <= 1'b0;
			if (cmd.div_start) begin
				dbusy_q <= 1'b1;
				dcnt_q  <= ($clog2(NUM_W+1))'(NUM_W);
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q - 1'b1;
				if (dcnt_q == ($clog2(NUM_W+1))'(1)) begin
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q  <= dot_q[ACC_W-1];
			zero_q <= (nq_q == '0) || (ne_q == '0);
			num_q  <= {(dot_q[ACC_W-1] ? ACC_W'(-dot_q) : ACC_W'(dot_q)), 15'd0};
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (dbusy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (rshift >= {1'b0, den_q}) begin
				rem_q <= rshift - {1'b0, den_q};
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rshift;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	// saturate signed quotient into Q1.15
	always_comb begin
		if (zero_q)
			sim = '0;
		else if (!neg_q)
			sim = (quo_q > NUM_W'(32767)) ? 17'sd32767 : 17'(quo_q);
		else
			sim = (quo_q > NUM_W'(32768)) ? -17'sd32768 : -17'(quo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found      <= 1'b0;
			best_sim   <= -16'sd32768;
			best_entry <= '0;
		end else if (cmd.clr_best) begin
			found      <= 1'b0;
			best_sim   <= -16'sd32768;
			best_entry <= '0;
		end else if (cmd.compare && (sim > 17'(best_sim))) begin
			found      <= 1'b1;
			best_sim   <= sim[15:0];
			best_entry <= cmd.ent;
		end
	end

	assign sts.root_done = rdone_q;
	assign sts.div_done  = ddone_q;
endmodule
`default_nettype wire

// ----- hw/rtl/cnm_ctrl.sv -----
// cnm_ctrl: search sequencer: walks entries, elements, roots, divide, compare.
// Depends on cnm_pkg.
`default_nettype none
module cnm_ctrl
	import cnm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [EIDX_W:0]  len,
	input  wire logic [CNT_W-1:0] used,
	input  wire cnm_sts_t         sts,
	output cnm_cmd_t              cmd,
	output logic                  busy,
	output logic                  finish
);
	typedef enum logic [2:0] {IDLE, READ, DRAIN, ROOT, DIV, CMP, NEXT} state_t;
	state_t state_q;
	logic [EIDX_W:0]  len_q;
	logic [EIDX_W:0]  ecnt_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] ent_q;
	logic [1:0]       drain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			len_q   <= '0;
			ecnt_q  <= '0;
			used_q  <= '0;
			ent_q   <= '0;
			drain_q <= '0;
			cmd     <= '0;
			busy    <= 1'b0;
			finish  <= 1'b0;
		end else begin
			cmd    <= '0;
			finish <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (go) begin
						busy         <= 1'b1;
						len_q        <= len;
						used_q       <= used;
						ent_q        <= '0;
						cmd.clr_best <= 1'b1;
						cmd.clr_acc  <= 1'b1;
						ecnt_q       <= '0;
						state_q      <= (used == '0) ? NEXT : READ;
					end
				end
				READ: begin
					cmd.rd_en  <= 1'b1;
					cmd.acc_en <= 1'b1;
					cmd.ent    <= ent_q[ENT_W-1:0];
					cmd.elem   <= ecnt_q[EIDX_W-1:0];
					ecnt_q     <= ecnt_q + 1'b1;
					if (ecnt_q + 1'b1 == len_q) begin
						drain_q <= '0;
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					cmd.acc_en <= 1'b1;
					drain_q    <= drain_q + 1'b1;
					if (drain_q == 2'd3) begin
						cmd.acc_en     <= 1'b0;
						cmd.root_start <= 1'b1;
						state_q        <= ROOT;
					end
				end
				ROOT: begin
					if (sts.root_done) begin
						cmd.div_start <= 1'b1;
						state_q       <= DIV;
					end
				end
				DIV: begin
					if (sts.div_done) begin
						cmd.compare <= 1'b1;
						cmd.ent     <= ent_q[ENT_W-1:0];
						state_q     <= CMP;
					end
				end
				CMP: begin
					ent_q       <= ent_q + 1'b1;
					ecnt_q      <= '0;
					cmd.clr_acc <= 1'b1;
					state_q     <= (ent_q + 1'b1 >= used_q) ? NEXT : READ;
				end
				NEXT: begin
					finish  <= 1'b1;
					busy    <= 1'b0;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/cosine_nearest_match_core.sv -----
// Cosine nearest-match core: a load or a non-final query element is written when
// accepted and busy stays low. A final query element starts a search that runs
// the shared multiply-accumulate over the first len elements of every entry in
// use (followed by a pipeline drain), then two concurrent serial square roots,
// a restoring divide and a compare for each entry. busy drops in the cycle
// before the result; result is shown for one cycle with result_valid and the
// receiver cannot stall it.
// Depends on cnm_pkg, cnm_ctrl, cnm_datapath.
`default_nettype none
module cosine_nearest_match_core
	import cnm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire in_item_t    item,
	output logic             result_valid,
	output out_item_t        result,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	logic signed [15:0] thr_q;
	logic [CNT_W-1:0]   count_q;
	logic               accept, go, ctrl_busy, finish;
	logic [EIDX_W:0]    len;
	logic [CNT_W-1:0]   used;
	cnm_cmd_t           cmd;
	cnm_sts_t           sts;
	logic [ENT_W-1:0]   best_entry;
	logic signed [15:0] best_sim;
	logic               found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= 16'sd16384;
			count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q   <= cfg_data;
				REG_COUNT:     count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy   = ctrl_busy;
	assign accept = start && !ctrl_busy;
	assign go     = accept && item.mode && item.query_last;
	assign len    = (EIDX_W+1)'(item.element_index) + 1'b1;
	assign used   = (count_q > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : count_q;

	cnm_ctrl u_ctrl (.clk, .arst_n, .go, .len, .used, .sts, .cmd,
		.busy(ctrl_busy), .finish);

	cnm_datapath u_dp (.clk, .arst_n,
		.wr_entry(accept && !item.mode), .wr_query(accept && item.mode),
		.item, .cmd, .sts, .best_entry, .best_sim, .found);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else
			result_valid <= finish;
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result.matched    <= found && (best_sim >= thr_q);
			result.best_entry <= best_entry;
			result.best_score <= best_sim;
		end
	end

`ifndef SYNTHESIS
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> busy) else $error("search did not start");
	a_res_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(finish)) else $error("stray result");
	a_no_double: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("double result");
`endif
endmodule
`default_nettype wire
